// ----- src/aema_pkg.sv -----
// ----------------------------------------------------------------------------
// aema_pkg
// Shared constants, types and helpers of the audio error metric accumulator.
// ----------------------------------------------------------------------------
package aema_pkg;

  localparam int MAX_CHANNELS    = 8;
  localparam int SLOT_W          = $clog2(MAX_CHANNELS);
  localparam int IDX_W           = 4;
  localparam int CH_GROW         = $clog2(MAX_CHANNELS);
  localparam int CNT_W           = 4;
  localparam int SHIFT_W         = 5;
  localparam int SHIFT_MAX       = 8;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 8;

  localparam int ACC_W    = 128;
  localparam int HALF_W   = 64;
  localparam int SQ_IN_W  = 64;
  localparam int PEAK_W   = 44;
  localparam int FRAMES_W = 32;

  localparam logic [SQ_IN_W-1:0] PEAK_MAX = (SQ_IN_W'(1) << PEAK_W) - SQ_IN_W'(1);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_SHIFT   = 1'd1;

  localparam logic [CNT_W-1:0]   CHANNEL_COUNT_RESET = 4'd2;
  localparam logic [SHIFT_W-1:0] SCALE_SHIFT_RESET   = 5'd0;

  typedef struct packed {
    logic              valid;
    logic              frame_end;
    logic              eos;
    logic [SLOT_W-1:0] slot;
  } aema_ctl_t;

  typedef struct packed {
    logic             ovf;
    logic [ACC_W-1:0] sum;
  } sat_sum_t;

  typedef struct packed {
    logic              over;
    logic [PEAK_W-1:0] value;
  } peak_t;

  // 128-bit add that sticks at all ones on carry out
  function automatic sat_sum_t sat_add(input logic [ACC_W-1:0] a,
                                       input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    sat_sum_t       r;
    s     = {1'b0, a} + {1'b0, b};
    r.ovf = s[ACC_W];
    r.sum = s[ACC_W] ? '1 : s[ACC_W-1:0];
    return r;
  endfunction

  // limit a magnitude to the peak field
  function automatic peak_t peak_clip(input logic [SQ_IN_W-1:0] m);
    peak_t r;
    r.over  = m > PEAK_MAX;
    r.value = r.over ? PEAK_MAX[PEAK_W-1:0] : m[PEAK_W-1:0];
    return r;
  endfunction

endpackage

// ----- src/aema_if.sv -----
// ----------------------------------------------------------------------------
// aema_in_if / aema_out_if
// Valid/ready channels for sample pairs and metric results.
// ----------------------------------------------------------------------------
interface aema_in_if #(
  parameter int SAMPLE_BITS = aema_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] orig_sample;
  logic signed [SAMPLE_BITS-1:0] test_sample;
  logic                          end_of_stream;

  modport source (output valid, output orig_sample, output test_sample,
                  output end_of_stream, input ready);
  modport sink   (input valid, input orig_sample, input test_sample,
                  input end_of_stream, output ready);
endinterface

interface aema_out_if ();
  import aema_pkg::*;
  logic                valid;
  logic                ready;
  logic [IDX_W-1:0]    channel_index;
  logic [HALF_W-1:0]   err_sq_high;
  logic [HALF_W-1:0]   err_sq_low;
  logic [HALF_W-1:0]   sig_sq_high;
  logic [HALF_W-1:0]   sig_sq_low;
  logic [PEAK_W-1:0]   abs_err_peak;
  logic [FRAMES_W-1:0] frame_count;
  logic                saturated;
  logic                last_result;

  modport source (output valid, output channel_index, output err_sq_high,
                  output err_sq_low, output sig_sq_high, output sig_sq_low,
                  output abs_err_peak, output frame_count, output saturated,
                  output last_result, input ready);
  modport sink   (input valid, input channel_index, input err_sq_high,
                  input err_sq_low, input sig_sq_high, input sig_sq_low,
                  input abs_err_peak, input frame_count, input saturated,
                  input last_result, output ready);
endinterface

// ----- src/aema_square.sv -----
// ----------------------------------------------------------------------------
// aema_square
// Two-stage 64-bit squarer: 32-bit partial products, then one wide add.
// ----------------------------------------------------------------------------
module aema_square (
  input  logic                          clk,
  input  logic [aema_pkg::SQ_IN_W-1:0]  mag,
  output logic [aema_pkg::ACC_W-1:0]    square
);
  import aema_pkg::*;

  localparam int PART_W = SQ_IN_W / 2;

  logic [SQ_IN_W-1:0] p_lo;
  logic [SQ_IN_W-1:0] p_cross;
  logic [SQ_IN_W-1:0] p_hi;

  always_ff @(posedge clk) begin
    p_lo    <= mag[PART_W-1:0] * mag[PART_W-1:0];
    p_cross <= mag[PART_W-1:0] * mag[SQ_IN_W-1:PART_W];
    p_hi    <= mag[SQ_IN_W-1:PART_W] * mag[SQ_IN_W-1:PART_W];
  end

  // cross term counts twice, hence the extra bit of shift
  always_ff @(posedge clk) begin
    square <= {p_hi, p_lo}
            + {{(ACC_W - SQ_IN_W - PART_W - 1){1'b0}}, p_cross, {(PART_W + 1){1'b0}}};
  end

endmodule

// ----- src/aema_front.sv -----
// ----------------------------------------------------------------------------
// aema_front
// Input capture, test scaling, channel tracking, differences and frame totals.
// ----------------------------------------------------------------------------
module aema_front #(
  parameter int SAMPLE_BITS = aema_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = aema_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  aema_in_if.sink                              samples,
  input  logic [aema_pkg::CNT_W-1:0]           chan_count,
  input  logic [aema_pkg::SHIFT_W-1:0]         shift_right,
  input  logic                                 readout_done,
  output aema_pkg::aema_ctl_t                  ctl,
  output logic [SAMPLE_BITS+FRAC_BITS+aema_pkg::SHIFT_MAX:0] chan_err,
  output logic [SAMPLE_BITS+FRAC_BITS-1:0]     chan_sig,
  output logic [SAMPLE_BITS+FRAC_BITS+aema_pkg::SHIFT_MAX+aema_pkg::CH_GROW:0] mid_err,
  output logic [SAMPLE_BITS+FRAC_BITS+aema_pkg::CH_GROW-1:0] mid_sig
);
  import aema_pkg::*;

  localparam int X_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int Y_W  = X_W + SHIFT_MAX;
  localparam int D_W  = Y_W + 1;
  localparam int XT_W = X_W + CH_GROW;
  localparam int YT_W = Y_W + CH_GROW;
  localparam int MD_W = YT_W + 1;

  logic                    busy;
  logic                    accept;
  logic [SLOT_W-1:0]       chan_position;
  logic [SLOT_W-1:0]       pos_eff;
  logic [SLOT_W-1:0]       last_slot;
  logic                    frame_end;
  logic signed [Y_W-1:0]   t_up;
  logic signed [Y_W-1:0]   y_in;
  logic signed [X_W-1:0]   x_in;

  aema_ctl_t               a_ctl;
  logic signed [X_W-1:0]   a_x;
  logic signed [Y_W-1:0]   a_y;
  logic signed [D_W-1:0]   a_diff;

  logic signed [XT_W-1:0]  tot_x;
  logic signed [YT_W-1:0]  tot_y;
  logic signed [XT_W-1:0]  tot_x_next;
  logic signed [YT_W-1:0]  tot_y_next;

  aema_ctl_t               b_ctl;
  logic [D_W-1:0]          b_d;
  logic [X_W-1:0]          b_e;
  logic signed [XT_W-1:0]  b_xt;
  logic signed [YT_W-1:0]  b_yt;
  logic signed [MD_W-1:0]  b_mdiff;

  assign samples.ready = !busy;
  assign accept        = samples.valid && !busy;

  // position beyond a lowered count folds onto the last channel
  assign last_slot = SLOT_W'(chan_count - CNT_W'(1));
  assign pos_eff   = ({1'b0, chan_position} >= chan_count) ? last_slot : chan_position;
  assign frame_end = (pos_eff == last_slot) || samples.end_of_stream;

  assign x_in = X_W'(samples.orig_sample) <<< FRAC_BITS;
  assign t_up = Y_W'(samples.test_sample) <<< (FRAC_BITS + SHIFT_MAX);
  assign y_in = t_up >>> shift_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      chan_position <= '0;
      a_ctl         <= '0;
    end else begin
      if (accept && samples.end_of_stream) begin
        busy <= 1'b1;
      end else if (readout_done) begin
        busy <= 1'b0;
      end
      if (accept) begin
        chan_position <= frame_end ? '0 : pos_eff + SLOT_W'(1);
      end
      a_ctl.valid     <= accept;
      a_ctl.frame_end <= frame_end;
      a_ctl.eos       <= samples.end_of_stream;
      a_ctl.slot      <= pos_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_x <= x_in;
      a_y <= y_in;
    end
  end

  // frame totals
  assign tot_x_next = tot_x + XT_W'(a_x);
  assign tot_y_next = tot_y + YT_W'(a_y);
  assign a_diff     = D_W'(a_x) - D_W'(a_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      tot_x <= '0;
      tot_y <= '0;
      b_ctl <= '0;
      ctl   <= '0;
    end else begin
      if (a_ctl.valid) begin
        tot_x <= a_ctl.frame_end ? '0 : tot_x_next;
        tot_y <= a_ctl.frame_end ? '0 : tot_y_next;
      end
      b_ctl <= a_ctl;
      ctl   <= b_ctl;
    end
  end

  assign b_mdiff = MD_W'(b_xt) - MD_W'(b_yt);

  always_ff @(posedge clk) begin
    b_d      <= a_diff[D_W-1] ? D_W'(-a_diff) : D_W'(a_diff);
    b_e      <= a_x[X_W-1] ? X_W'(-a_x) : X_W'(a_x);
    b_xt     <= tot_x_next;
    b_yt     <= tot_y_next;
    chan_err <= b_d;
    chan_sig <= b_e;
    mid_err  <= b_mdiff[MD_W-1] ? MD_W'(-b_mdiff) : MD_W'(b_mdiff);
    mid_sig  <= b_xt[XT_W-1] ? XT_W'(-b_xt) : XT_W'(b_xt);
  end

endmodule

// ----- src/aema_accum.sv -----
// ----------------------------------------------------------------------------
// aema_accum
// Saturating per-channel and mid accumulators, peak tracking and readout.
// ----------------------------------------------------------------------------
module aema_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  aema_pkg::aema_ctl_t           ctl,
  input  logic [aema_pkg::SQ_IN_W-1:0]  chan_peak,
  input  logic [aema_pkg::SQ_IN_W-1:0]  mid_peak,
  input  logic [aema_pkg::ACC_W-1:0]    chan_err_sq,
  input  logic [aema_pkg::ACC_W-1:0]    chan_sig_sq,
  input  logic [aema_pkg::ACC_W-1:0]    mid_err_sq,
  input  logic [aema_pkg::ACC_W-1:0]    mid_sig_sq,
  input  logic [aema_pkg::CNT_W-1:0]    chan_count,
  output logic                          readout_done,
  aema_out_if.source                    results
);
  import aema_pkg::*;

  aema_ctl_t           ctl_d;
  aema_ctl_t           ctl_e;
  peak_t               peak_d;
  peak_t               peak_e;
  peak_t               mpeak_d;
  peak_t               mpeak_e;

  logic [ACC_W-1:0]    err_acc  [MAX_CHANNELS];
  logic [ACC_W-1:0]    sig_acc  [MAX_CHANNELS];
  logic [PEAK_W-1:0]   peak_acc [MAX_CHANNELS];
  logic                marks    [MAX_CHANNELS];
  logic [ACC_W-1:0]    mid_err_acc;
  logic [ACC_W-1:0]    mid_sig_acc;
  logic [PEAK_W-1:0]   mid_peak_acc;
  logic                mid_mark;
  logic [FRAMES_W-1:0] frame_counter;

  logic                rd_active;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_is_mid;
  logic                load;
  logic                out_valid;
  logic [SLOT_W-1:0]   read_slot;

  logic [ACC_W-1:0]    r_err;
  logic [ACC_W-1:0]    r_sig;
  logic [PEAK_W-1:0]   r_peak;
  logic                r_mark;
  sat_sum_t            err_add;
  sat_sum_t            sig_add;
  sat_sum_t            mid_err_add;
  sat_sum_t            mid_sig_add;

  // peak clip runs alongside the squarer stages
  always_ff @(posedge clk) begin
    peak_d  <= peak_clip(chan_peak);
    mpeak_d <= peak_clip(mid_peak);
    peak_e  <= peak_d;
    mpeak_e <= mpeak_d;
  end

  assign rd_is_mid    = rd_idx == chan_count;
  assign load         = rd_active && (!out_valid || results.ready);
  assign readout_done = load && rd_is_mid;

  // one read port: readout address while draining, update slot otherwise
  assign read_slot = rd_active ? rd_idx[SLOT_W-1:0] : ctl_e.slot;
  assign r_err     = err_acc[read_slot];
  assign r_sig     = sig_acc[read_slot];
  assign r_peak    = peak_acc[read_slot];
  assign r_mark    = marks[read_slot];

  assign err_add     = sat_add(r_err, chan_err_sq);
  assign sig_add     = sat_add(r_sig, chan_sig_sq);
  assign mid_err_add = sat_add(mid_err_acc, mid_err_sq);
  assign mid_sig_add = sat_add(mid_sig_acc, mid_sig_sq);

  always_ff @(posedge clk) begin
    if (rst || readout_done) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        err_acc[i]  <= '0;
        sig_acc[i]  <= '0;
        peak_acc[i] <= '0;
        marks[i]    <= 1'b0;
      end
      mid_err_acc   <= '0;
      mid_sig_acc   <= '0;
      mid_peak_acc  <= '0;
      mid_mark      <= 1'b0;
      frame_counter <= '0;
    end else if (ctl_e.valid) begin
      err_acc[ctl_e.slot] <= err_add.sum;
      sig_acc[ctl_e.slot] <= sig_add.sum;
      if (peak_e.value > r_peak) begin
        peak_acc[ctl_e.slot] <= peak_e.value;
      end
      if (err_add.ovf || sig_add.ovf || peak_e.over) begin
        marks[ctl_e.slot] <= 1'b1;
      end
      if (ctl_e.frame_end) begin
        mid_err_acc <= mid_err_add.sum;
        mid_sig_acc <= mid_sig_add.sum;
        if (mpeak_e.value > mid_peak_acc) begin
          mid_peak_acc <= mpeak_e.value;
        end
        if (mid_err_add.ovf || mid_sig_add.ovf || mpeak_e.over) begin
          mid_mark <= 1'b1;
        end
        if (frame_counter != '1) begin
          frame_counter <= frame_counter + FRAMES_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d     <= '0;
      ctl_e     <= '0;
      rd_active <= 1'b0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      ctl_d <= ctl;
      ctl_e <= ctl_d;
      // start the drain once the closing pair has been accumulated
      if (ctl_e.valid && ctl_e.eos) begin
        rd_active <= 1'b1;
        rd_idx    <= '0;
      end else if (load) begin
        if (rd_is_mid) begin
          rd_active <= 1'b0;
        end else begin
          rd_idx <= rd_idx + IDX_W'(1);
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.channel_index   <= rd_idx;
      results.err_sq_high     <= rd_is_mid ? mid_err_acc[ACC_W-1:HALF_W] : r_err[ACC_W-1:HALF_W];
      results.err_sq_low      <= rd_is_mid ? mid_err_acc[HALF_W-1:0] : r_err[HALF_W-1:0];
      results.sig_sq_high     <= rd_is_mid ? mid_sig_acc[ACC_W-1:HALF_W] : r_sig[ACC_W-1:HALF_W];
      results.sig_sq_low      <= rd_is_mid ? mid_sig_acc[HALF_W-1:0] : r_sig[HALF_W-1:0];
      results.abs_err_peak    <= rd_is_mid ? mid_peak_acc : r_peak;
      results.frame_count     <= frame_counter;
      results.saturated       <= rd_is_mid ? mid_mark : r_mark;
      results.last_result     <= rd_is_mid;
    end
  end

  assign results.valid = out_valid;

endmodule

// ----- src/audio_error_metric_accumulator.sv -----
// ----------------------------------------------------------------------------
// audio_error_metric_accumulator
// Squared error, energy and peak error per channel and for the mid signal.
// ----------------------------------------------------------------------------
//  port      | dir | kind        | moves
//  ----------+-----+-------------+------------------------------------------
//  samples   | in  | valid/ready | orig/test sample pair, end_of_stream
//  results   | out | valid/ready | one record per channel, then mid record
//  cfg_*     | in  | write only  | channel_count (0), scale_shift (1)
//
//  One sample pair per cycle while the input is not held off; a pair passes
//  through the stages capture, difference, mid difference, two squarer
//  stages and accumulate. After an end_of_stream transfer the input holds
//  off until the mid record is loaded: the pipeline drains, and then
//  channel_count + 1 result loads follow, each waiting on results.ready.
//  Reset leaves all sums zero.
// ----------------------------------------------------------------------------
module audio_error_metric_accumulator #(
  parameter int SAMPLE_BITS = aema_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = aema_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [aema_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aema_pkg::CFG_DATA_W-1:0]   cfg_data,
  aema_in_if.sink                           samples,
  aema_out_if.source                        results
);
  import aema_pkg::*;

  localparam int X_W  = SAMPLE_BITS + FRAC_BITS;
  localparam int Y_W  = X_W + SHIFT_MAX;
  localparam int D_W  = Y_W + 1;
  localparam int XT_W = X_W + CH_GROW;
  localparam int YT_W = Y_W + CH_GROW;
  localparam int MD_W = YT_W + 1;

  logic [CNT_W-1:0]          count_reg;
  logic signed [SHIFT_W-1:0] shift_reg;
  logic [CNT_W-1:0]          chan_count;
  logic signed [SHIFT_W-1:0] shift_clamped;
  logic signed [SHIFT_W:0]   shift_right_wide;
  logic [SHIFT_W-1:0]        shift_right;
  logic                      readout_done;

  aema_ctl_t                 ctl;
  logic [D_W-1:0]            chan_err;
  logic [X_W-1:0]            chan_sig;
  logic [MD_W-1:0]           mid_err;
  logic [XT_W-1:0]           mid_sig;
  logic [ACC_W-1:0]          chan_err_sq;
  logic [ACC_W-1:0]          chan_sig_sq;
  logic [ACC_W-1:0]          mid_err_sq;
  logic [ACC_W-1:0]          mid_sig_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= CHANNEL_COUNT_RESET;
      shift_reg <= SCALE_SHIFT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_CHANNEL_COUNT: count_reg <= cfg_data[CNT_W-1:0];
        REG_SCALE_SHIFT:   shift_reg <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp the count to 1..MAX_CHANNELS and the shift to +-SHIFT_MAX
  assign chan_count = (count_reg == '0) ? CNT_W'(1)
                    : (count_reg > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS)
                    : count_reg;
  assign shift_clamped = (shift_reg < -SHIFT_W'(SHIFT_MAX)) ? -SHIFT_W'(SHIFT_MAX)
                       : (shift_reg > SHIFT_W'(SHIFT_MAX))  ? SHIFT_W'(SHIFT_MAX)
                       : shift_reg;
  assign shift_right_wide = (SHIFT_W+1)'(SHIFT_MAX) - (SHIFT_W+1)'(shift_clamped);
  assign shift_right      = shift_right_wide[SHIFT_W-1:0];

  aema_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples),
    .chan_count   (chan_count),
    .shift_right  (shift_right),
    .readout_done (readout_done),
    .ctl          (ctl),
    .chan_err     (chan_err),
    .chan_sig     (chan_sig),
    .mid_err      (mid_err),
    .mid_sig      (mid_sig)
  );

  aema_square u_sq_chan_err (
    .clk    (clk),
    .mag    (SQ_IN_W'(chan_err)),
    .square (chan_err_sq)
  );

  aema_square u_sq_chan_sig (
    .clk    (clk),
    .mag    (SQ_IN_W'(chan_sig)),
    .square (chan_sig_sq)
  );

  aema_square u_sq_mid_err (
    .clk    (clk),
    .mag    (SQ_IN_W'(mid_err)),
    .square (mid_err_sq)
  );

  aema_square u_sq_mid_sig (
    .clk    (clk),
    .mag    (SQ_IN_W'(mid_sig)),
    .square (mid_sig_sq)
  );

  aema_accum u_accum (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .chan_peak    (SQ_IN_W'(chan_err)),
    .mid_peak     (SQ_IN_W'(mid_err)),
    .chan_err_sq  (chan_err_sq),
    .chan_sig_sq  (chan_sig_sq),
    .mid_err_sq   (mid_err_sq),
    .mid_sig_sq   (mid_sig_sq),
    .chan_count   (chan_count),
    .readout_done (readout_done),
    .results      (results)
  );

endmodule
